### rtl/core/rdf_pkg.sv
// rdf_pkg: shared constants, codes and helpers of the record decimation filter
// no dependencies

package rdf_pkg;

   // repetitions of one task iteration for the multi-instance sensor types
   localparam int IMU_COUNT   = 2;
   localparam int BARO_COUNT  = 2;
   localparam int MAG_COUNT   = 1;
   localparam int ACCEL_COUNT = 1;

   localparam int NUM_TYPES = 11;
   localparam int NUM_DECIM = 7;

   localparam int TYPE_W   = 4;
   localparam int DIDX_W   = 3;
   localparam int CNT_W    = 8;
   localparam int REPS_W   = 4;
   localparam int RATE_W   = 4;
   localparam int MASK_W   = 11;
   localparam int PERIOD_W = RATE_W + 1 + REPS_W;
   localparam int DATA_W   = 32;
   localparam int ADDR_W   = 3;

   // entry type codes
   localparam logic [TYPE_W-1:0] TYPE_IMU    = 4'd0;
   localparam logic [TYPE_W-1:0] TYPE_BARO   = 4'd1;
   localparam logic [TYPE_W-1:0] TYPE_MAG    = 4'd2;
   localparam logic [TYPE_W-1:0] TYPE_ACCEL  = 4'd3;
   localparam logic [TYPE_W-1:0] TYPE_FLIGHT = 4'd4;
   localparam logic [TYPE_W-1:0] TYPE_LAST   = 4'd10;

   // recorder status codes
   localparam logic [1:0] STATUS_OFF   = 2'd0;
   localparam logic [1:0] STATUS_FILL  = 2'd1;
   localparam logic [1:0] STATUS_FLASH = 2'd2;

   // register index, taken from word address bit of the csr port
   localparam logic REG_TYPE_MASK  = 1'b0;
   localparam logic REG_RATE_INDEX = 1'b1;

   localparam logic [MASK_W-1:0] TYPE_MASK_RESET = 11'h7FF;
   localparam logic [DATA_W-1:0] MOST_NEG        = 32'h8000_0000;

   // counter step request from the datapath to the decimation counters
   typedef struct packed {
      logic              step;
      logic [TYPE_W-1:0] entry_type;
   } decim_req_type;

   function automatic logic [REPS_W-1:0] reps_of(input logic [DIDX_W-1:0] idx);
      logic [REPS_W-1:0] reps;
      case (idx)
         TYPE_IMU[DIDX_W-1:0]:   reps = REPS_W'(IMU_COUNT);
         TYPE_BARO[DIDX_W-1:0]:  reps = REPS_W'(BARO_COUNT);
         TYPE_MAG[DIDX_W-1:0]:   reps = REPS_W'(MAG_COUNT);
         TYPE_ACCEL[DIDX_W-1:0]: reps = REPS_W'(ACCEL_COUNT);
         default:                reps = REPS_W'(1);
      endcase
      return reps;
   endfunction

endpackage

### rtl/core/rdf_decim_ctr.sv
// rdf_decim_ctr: per-type decimation counters and the skip decision
// depends on rdf_pkg

module rdf_decim_ctr import rdf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              clear,
   input  logic [RATE_W-1:0] rate_index,
   input  decim_req_type     req,
   output logic              skip
);

   logic [CNT_W-1:0]    cnt_ff [NUM_DECIM];
   logic [CNT_W-1:0]    cnt_in [NUM_DECIM];
   logic                decimated;
   logic [DIDX_W-1:0]   idx;
   logic [REPS_W-1:0]   reps;
   logic [PERIOD_W-1:0] period;
   logic [CNT_W-1:0]    cnt_cur;
   logic [PERIOD_W-1:0] cnt_inc;

   // counters only ever hold values below the period (cleared on rate change),
   // so the modulo reduces to a wrap compare
   assign decimated = (req.entry_type < TYPE_W'(NUM_DECIM)) && (rate_index != '0);
   assign idx       = req.entry_type[DIDX_W-1:0];
   assign reps      = reps_of(idx);
   assign period    = PERIOD_W'((PERIOD_W'(rate_index) + PERIOD_W'(1)) * PERIOD_W'(reps));
   assign cnt_cur   = (idx < DIDX_W'(NUM_DECIM)) ? cnt_ff[idx] : '0;
   assign cnt_inc   = PERIOD_W'(cnt_cur) + PERIOD_W'(1);
   assign skip      = decimated && (PERIOD_W'(cnt_cur) >= PERIOD_W'(reps));

   always_comb begin
      for (int i = 0; i < NUM_DECIM; i++) begin
         cnt_in[i] = cnt_ff[i];
         if (clear) begin
            cnt_in[i] = '0;
         end else if (req.step && decimated && (idx == DIDX_W'(i))) begin
            cnt_in[i] = (cnt_inc == period) ? '0 : cnt_inc[CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_DECIM; i++) begin
         if (reset) begin
            cnt_ff[i] <= '0;
         end else begin
            cnt_ff[i] <= cnt_in[i];
         end
      end
   end

endmodule

### rtl/core/record_decimation_filter.sv
// record_decimation_filter: top level of the log entry decimation filter
// depends on rdf_pkg and rdf_decim_ctr
//
// usage
// - req channel (valid/ready) carries one log entry per item: timestamp, type,
//   recorder status and the flight info height, velocity and acceleration
// - rsp channel (valid/ready) returns one item per entry: the keep flag and the
//   running maxima of height, velocity and acceleration with their timestamps
// - csr port (apb style, 32-bit data): word 0 type_mask, word 1 rate_index;
//   writing rate_index clears all decimation counters; write only when idle
// - an accepted entry moves into the input register and then into the result
//   register, where rsp_valid rises; one item per cycle is sustained while rsp
//   is taken, set by the single compute stage between the input register
//   and the result register (counter step and three max compares in parallel)
// - a stalled rsp holds the result register; the input register still takes
//   one more item, after which req_ready drops until the result is taken
// - reset clears counters, maxima to the most negative value, times to zero,
//   type_mask to all ones and rate_index to zero; both channels empty

module record_decimation_filter import rdf_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [31:0]              req_timestamp,
   input  logic [TYPE_W-1:0]        req_entry_type,
   input  logic [1:0]               req_recorder_status,
   input  logic signed [31:0]       req_height,
   input  logic signed [31:0]       req_velocity,
   input  logic signed [31:0]       req_acceleration,

   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_keep,
   output logic signed [31:0]       rsp_peak_height,
   output logic [31:0]              rsp_peak_height_time,
   output logic signed [31:0]       rsp_peak_velocity,
   output logic [31:0]              rsp_peak_velocity_time,
   output logic signed [31:0]       rsp_peak_accel,
   output logic [31:0]              rsp_peak_accel_time,

   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [ADDR_W-1:0]        csr_paddr,
   input  logic [DATA_W-1:0]        csr_pwdata,
   output logic [DATA_W-1:0]        csr_prdata,
   output logic                     csr_pready
);

   // configuration registers
   logic [MASK_W-1:0]  type_mask_ff, type_mask_in;
   logic [RATE_W-1:0]  rate_index_ff, rate_index_in;
   logic               csr_wr;
   logic               rate_wr;

   // input register stage
   logic               s1_valid_ff, s1_valid_in;
   logic [31:0]        s1_ts_ff;
   logic [TYPE_W-1:0]  s1_type_ff;
   logic [1:0]         s1_status_ff;
   logic signed [31:0] s1_height_ff, s1_velocity_ff, s1_accel_ff;

   // result register stage
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_keep_ff, rsp_keep_in;

   // running maxima, also drive the result payload directly
   logic signed [31:0] pk_height_ff, pk_height_in;
   logic signed [31:0] pk_velocity_ff, pk_velocity_in;
   logic signed [31:0] pk_accel_ff, pk_accel_in;
   logic [31:0]        pk_height_t_ff, pk_height_t_in;
   logic [31:0]        pk_velocity_t_ff, pk_velocity_t_in;
   logic [31:0]        pk_accel_t_ff, pk_accel_t_in;

   logic               req_accept;
   logic               out_free;
   logic               s1_adv;
   logic [15:0]        mask_ext;
   logic               admitted;
   logic               peak_upd;
   logic               skip;
   decim_req_type      decim_req;

   // handshake: the result register frees when empty or being taken
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign s1_adv     = s1_valid_ff && out_free;
   assign req_ready  = !s1_valid_ff || out_free;
   assign req_accept = req_valid && req_ready;

   assign s1_valid_in  = req_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_adv ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // admission: status at least fill-queue and mask bit set; types above ten
   // see a zero bit in the extended mask
   assign mask_ext = {(16 - MASK_W)'(0), type_mask_ff};
   assign admitted = (s1_status_ff != STATUS_OFF) && (s1_type_ff <= TYPE_LAST)
                     && mask_ext[s1_type_ff];
   assign peak_upd = s1_adv && admitted && (s1_type_ff == TYPE_FLIGHT)
                     && (s1_status_ff == STATUS_FLASH);

   assign decim_req.step       = s1_adv && admitted;
   assign decim_req.entry_type = s1_type_ff;

   rdf_decim_ctr u_decim (
      .clock      (clock),
      .reset      (reset),
      .clear      (rate_wr),
      .rate_index (rate_index_ff),
      .req        (decim_req),
      .skip       (skip)
   );

   assign rsp_keep_in = s1_adv ? (admitted && !skip) : rsp_keep_ff;

   // strict greater-than so an equal value never moves the timestamp
   always_comb begin
      pk_height_in     = pk_height_ff;
      pk_height_t_in   = pk_height_t_ff;
      pk_velocity_in   = pk_velocity_ff;
      pk_velocity_t_in = pk_velocity_t_ff;
      pk_accel_in      = pk_accel_ff;
      pk_accel_t_in    = pk_accel_t_ff;
      if (peak_upd) begin
         if (s1_height_ff > pk_height_ff) begin
            pk_height_in   = s1_height_ff;
            pk_height_t_in = s1_ts_ff;
         end
         if (s1_velocity_ff > pk_velocity_ff) begin
            pk_velocity_in   = s1_velocity_ff;
            pk_velocity_t_in = s1_ts_ff;
         end
         if (s1_accel_ff > pk_accel_ff) begin
            pk_accel_in   = s1_accel_ff;
            pk_accel_t_in = s1_ts_ff;
         end
      end
   end

   // csr decode by word address bit, byte offset ignored
   assign csr_wr  = csr_psel && csr_penable && csr_pwrite;
   assign rate_wr = csr_wr && (csr_paddr[2] == REG_RATE_INDEX);

   always_comb begin
      type_mask_in  = type_mask_ff;
      rate_index_in = rate_index_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            REG_TYPE_MASK:  type_mask_in  = csr_pwdata[MASK_W-1:0];
            REG_RATE_INDEX: rate_index_in = csr_pwdata[RATE_W-1:0];
            default:        type_mask_in  = type_mask_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_TYPE_MASK:  csr_prdata = {(DATA_W - MASK_W)'(0), type_mask_ff};
         REG_RATE_INDEX: csr_prdata = {(DATA_W - RATE_W)'(0), rate_index_ff};
         default:        csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         rsp_keep_ff      <= 1'b0;
         type_mask_ff     <= TYPE_MASK_RESET;
         rate_index_ff    <= '0;
         pk_height_ff     <= MOST_NEG;
         pk_velocity_ff   <= MOST_NEG;
         pk_accel_ff      <= MOST_NEG;
         pk_height_t_ff   <= '0;
         pk_velocity_t_ff <= '0;
         pk_accel_t_ff    <= '0;
      end else begin
         s1_valid_ff      <= s1_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         rsp_keep_ff      <= rsp_keep_in;
         type_mask_ff     <= type_mask_in;
         rate_index_ff    <= rate_index_in;
         pk_height_ff     <= pk_height_in;
         pk_velocity_ff   <= pk_velocity_in;
         pk_accel_ff      <= pk_accel_in;
         pk_height_t_ff   <= pk_height_t_in;
         pk_velocity_t_ff <= pk_velocity_t_in;
         pk_accel_t_ff    <= pk_accel_t_in;
      end
   end

   // input payload register, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ts_ff       <= req_timestamp;
         s1_type_ff     <= req_entry_type;
         s1_status_ff   <= req_recorder_status;
         s1_height_ff   <= req_height;
         s1_velocity_ff <= req_velocity;
         s1_accel_ff    <= req_acceleration;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_keep               = rsp_keep_ff;
   assign rsp_peak_height        = pk_height_ff;
   assign rsp_peak_height_time   = pk_height_t_ff;
   assign rsp_peak_velocity      = pk_velocity_ff;
   assign rsp_peak_velocity_time = pk_velocity_t_ff;
   assign rsp_peak_accel         = pk_accel_ff;
   assign rsp_peak_accel_time    = pk_accel_t_ff;

   // maxima never fall outside reset
   a_height_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (pk_height_ff >= $past(pk_height_ff)))
      else $error("peak height decreased");

   // a timestamp moves only together with its maximum
   a_accel_time_follows: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $stable(pk_accel_ff)) |-> $stable(pk_accel_t_ff))
      else $error("peak accel time changed without a new maximum");

   // entries of unknown type are never kept
   a_bad_type_dropped: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && (s1_type_ff > TYPE_LAST)) |=> !rsp_keep_ff)
      else $error("entry of unknown type kept");

   // the result register is only reloaded when free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> ($stable(rsp_keep_ff) && !$past(s1_adv)))
      else $error("stalled result overwritten");

endmodule

### tb/rdf_checker.sv
// rdf_checker: watches the entry, result and csr ports of the record decimation filter,
// predicts every result item from its own copy of the filter state and compares it
// depends on rdf_pkg

module rdf_checker import rdf_pkg::*; (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [31:0]        req_timestamp,
   input  logic [TYPE_W-1:0]  req_entry_type,
   input  logic [1:0]         req_recorder_status,
   input  logic signed [31:0] req_height,
   input  logic signed [31:0] req_velocity,
   input  logic signed [31:0] req_acceleration,

   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic               rsp_keep,
   input  logic signed [31:0] rsp_peak_height,
   input  logic [31:0]        rsp_peak_height_time,
   input  logic signed [31:0] rsp_peak_velocity,
   input  logic [31:0]        rsp_peak_velocity_time,
   input  logic signed [31:0] rsp_peak_accel,
   input  logic [31:0]        rsp_peak_accel_time,

   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [ADDR_W-1:0]  csr_paddr,
   input  logic [DATA_W-1:0]  csr_pwdata,
   input  logic [DATA_W-1:0]  csr_prdata,
   input  logic               csr_pready,

   output int                 fail_count,
   output int                 pending
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic               keep;
      logic signed [31:0] height;
      logic [31:0]        height_time;
      logic signed [31:0] velocity;
      logic [31:0]        velocity_time;
      logic signed [31:0] accel;
      logic [31:0]        accel_time;
   } filter_result_type;

   // shadow of the filter state
   logic [MASK_W-1:0]  type_mask;
   logic [RATE_W-1:0]  rate_index;
   logic [CNT_W-1:0]   decim_count [NUM_DECIM];
   logic signed [31:0] peak_val [3];
   logic [31:0]        peak_at [3];

   filter_result_type  expected_verdicts [$];
   int                 result_number;

   function automatic int repetitions(input logic [TYPE_W-1:0] kind);
      if (kind == TYPE_IMU)   return IMU_COUNT;
      if (kind == TYPE_BARO)  return BARO_COUNT;
      if (kind == TYPE_MAG)   return MAG_COUNT;
      if (kind == TYPE_ACCEL) return ACCEL_COUNT;
      return 1;
   endfunction

   // keep decision and running maxima for one entry; advances the shadow state
   function automatic filter_result_type filter_entry(
         input logic [31:0] ts, input logic [TYPE_W-1:0] kind, input logic [1:0] status,
         input logic signed [31:0] h, input logic signed [31:0] v,
         input logic signed [31:0] a);
      filter_result_type  r;
      logic signed [31:0] sample [3];
      int                 reps;
      int                 period;
      int                 cnt;
      sample[0] = h;
      sample[1] = v;
      sample[2] = a;
      r.keep = 1'b0;
      if (status >= STATUS_FILL && kind < NUM_TYPES && type_mask[kind]) begin
         r.keep = 1'b1;
         // maxima move before the decimation decision of the same entry
         if (kind == TYPE_FLIGHT && status == STATUS_FLASH) begin
            for (int k = 0; k < 3; k++) begin
               if (sample[k] > peak_val[k]) begin
                  peak_val[k] = sample[k];
                  peak_at[k]  = ts;
               end
            end
         end
         if (kind < NUM_DECIM && rate_index != '0) begin
            reps   = repetitions(kind);
            period = (int'(rate_index) + 1) * reps;
            cnt    = int'(decim_count[kind[DIDX_W-1:0]]);
            if (cnt % period >= reps)
               r.keep = 1'b0;
            decim_count[kind[DIDX_W-1:0]] = CNT_W'((cnt + 1) % period);
         end
      end
      r.height        = peak_val[0];
      r.height_time   = peak_at[0];
      r.velocity      = peak_val[1];
      r.velocity_time = peak_at[1];
      r.accel         = peak_val[2];
      r.accel_time    = peak_at[2];
      return r;
   endfunction

   function automatic string describe(input filter_result_type r);
      return $sformatf("keep %0b h %h@%h v %h@%h a %h@%h", r.keep, r.height, r.height_time,
                       r.velocity, r.velocity_time, r.accel, r.accel_time);
   endfunction

   function automatic bit count_failure();
      fail_count++;
      return fail_count <= REPORT_LIMIT;
   endfunction

   always @(posedge clock) begin
      filter_result_type got;
      filter_result_type want;
      logic [DATA_W-1:0] reg_value;
      if (reset) begin
         type_mask  = TYPE_MASK_RESET;
         rate_index = '0;
         for (int i = 0; i < NUM_DECIM; i++)
            decim_count[i] = '0;
         for (int k = 0; k < 3; k++) begin
            peak_val[k] = MOST_NEG;
            peak_at[k]  = '0;
         end
         expected_verdicts.delete();
         fail_count    = 0;
         result_number = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.keep          = rsp_keep;
            got.height        = rsp_peak_height;
            got.height_time   = rsp_peak_height_time;
            got.velocity      = rsp_peak_velocity;
            got.velocity_time = rsp_peak_velocity_time;
            got.accel         = rsp_peak_accel;
            got.accel_time    = rsp_peak_accel_time;
            if (expected_verdicts.size() == 0) begin
               if (count_failure())
                  $display("unexpected result item %0d: %s", result_number, describe(got));
            end else begin
               want = expected_verdicts.pop_front();
               if (got !== want && count_failure()) begin
                  $display("mismatch on result item %0d", result_number);
                  $display("   expected %s", describe(want));
                  $display("   actual   %s", describe(got));
               end
            end
            result_number++;
         end
         if (req_valid && req_ready)
            expected_verdicts.push_back(filter_entry(req_timestamp, req_entry_type,
               req_recorder_status, req_height, req_velocity, req_acceleration));
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr[ADDR_W-1:2] == REG_RATE_INDEX) begin
                  rate_index = csr_pwdata[RATE_W-1:0];
                  for (int i = 0; i < NUM_DECIM; i++)
                     decim_count[i] = '0;
               end else begin
                  type_mask = csr_pwdata[MASK_W-1:0];
               end
            end else begin
               reg_value = (csr_paddr[ADDR_W-1:2] == REG_RATE_INDEX) ?
                           DATA_W'(rate_index) : DATA_W'(type_mask);
               if (csr_prdata !== reg_value && count_failure())
                  $display("csr readback at %h: expected %h, actual %h",
                           csr_paddr, reg_value, csr_prdata);
            end
         end
      end
      pending = expected_verdicts.size();
   end

endmodule

### tb/tb_record_decimation_filter.sv
// tb_record_decimation_filter: stimulus and verdict for the record decimation filter
// depends on rdf_pkg, record_decimation_filter and rdf_checker

module tb_record_decimation_filter;
   import rdf_pkg::*;

   // longest legal quiet stretch is the long receiver hold-off plus a csr pair;
   // the watchdog allows many times that
   localparam int WATCHDOG_LIMIT = 2000;
   // hold-off long enough to fill the input and result registers and stall req
   localparam int LONG_STALL     = 80;
   // extra wait after the last result item catches a stray result item
   localparam int DRAIN_CYCLES   = 4;

   // status code three: admitted like fill-queue, never updates the maxima
   localparam logic [1:0]        STATUS_SPARE = 2'd3;
   localparam logic [DATA_W-1:0] MOST_POS     = 32'h7FFF_FFFF;

   typedef struct packed {
      logic [31:0]        timestamp;
      logic [TYPE_W-1:0]  entry_type;
      logic [1:0]         status;
      logic signed [31:0] height;
      logic signed [31:0] velocity;
      logic signed [31:0] acceleration;
   } log_entry_type;

   logic                     clock;
   logic                     reset;

   logic                     req_valid;
   logic                     req_ready;
   logic [31:0]              req_timestamp;
   logic [TYPE_W-1:0]        req_entry_type;
   logic [1:0]               req_recorder_status;
   logic signed [31:0]       req_height;
   logic signed [31:0]       req_velocity;
   logic signed [31:0]       req_acceleration;

   logic                     rsp_valid;
   logic                     rsp_ready;
   logic                     rsp_keep;
   logic signed [31:0]       rsp_peak_height;
   logic [31:0]              rsp_peak_height_time;
   logic signed [31:0]       rsp_peak_velocity;
   logic [31:0]              rsp_peak_velocity_time;
   logic signed [31:0]       rsp_peak_accel;
   logic [31:0]              rsp_peak_accel_time;

   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [ADDR_W-1:0]        csr_paddr;
   logic [DATA_W-1:0]        csr_pwdata;
   logic [DATA_W-1:0]        csr_prdata;
   logic                     csr_pready;

   int                       fail_count;
   int                       pending;

   // stimulus knobs, changed between phases
   int                       req_gap_pct;
   int                       rsp_gap_pct;
   bit                       stall_request;

   // entry clock and the slowly rising flight profile fed to the maxima
   logic [31:0]              now_ms;
   int                       trend [3];

   record_decimation_filter dut (.*);

   rdf_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side: random ready bursts, plus one long hold-off on request
   initial begin : rsp_drive
      int n;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_request) begin
            stall_request = 1'b0;
            rsp_ready     = 1'b0;
            repeat (LONG_STALL) @(negedge clock);
         end else if (rsp_gap_pct != 0 && $urandom_range(1, 100) <= rsp_gap_pct) begin
            rsp_ready = 1'b0;
            n         = $urandom_range(1, 15);
            repeat (n - 1) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   // ends the run when no item moves on either channel for too long
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // offer one item, with an optional gap first; valid stays up between items
   task automatic send_entry(input log_entry_type e);
      @(negedge clock);
      if (req_gap_pct != 0 && $urandom_range(1, 100) <= req_gap_pct) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_valid           = 1'b1;
      req_timestamp       = e.timestamp;
      req_entry_type      = e.entry_type;
      req_recorder_status = e.status;
      req_height          = e.height;
      req_velocity        = e.velocity;
      req_acceleration    = e.acceleration;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_fields(input logic [31:0] ts, input logic [TYPE_W-1:0] kind,
                              input logic [1:0] status, input logic signed [31:0] h,
                              input logic signed [31:0] v, input logic signed [31:0] a);
      log_entry_type e;
      e = '{timestamp: ts, entry_type: kind, status: status,
            height: h, velocity: v, acceleration: a};
      send_entry(e);
   endtask

   // drop valid, wait until every result item is back and the pipe is empty
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // apb write followed by a readback of the same register
   task automatic csr_access(input logic sel, input logic [DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = ADDR_W'({sel, 2'b00});
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   // unused upper data bits carry random junk, the register must ignore it
   task automatic configure(input logic [MASK_W-1:0] mask, input logic [RATE_W-1:0] rate);
      logic [DATA_W-1:0] pad;
      pad = $urandom;
      csr_access(REG_TYPE_MASK, {pad[DATA_W-1:MASK_W], mask});
      pad = $urandom;
      csr_access(REG_RATE_INDEX, {pad[DATA_W-1:RATE_W], rate});
   endtask

   function automatic logic [TYPE_W-1:0] random_type();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 5)
         return TYPE_W'($urandom_range(NUM_TYPES, 15));  // no mask bit, never kept
      if (pick < 35)
         return TYPE_FLIGHT;
      return TYPE_W'($urandom_range(0, NUM_TYPES - 1));
   endfunction

   function automatic log_entry_type random_entry(input logic [TYPE_W-1:0] kind);
      log_entry_type e;
      int            pick;
      now_ms += $urandom_range(0, 25);
      e.timestamp  = ($urandom_range(0, 15) == 0) ? $urandom : now_ms;
      e.entry_type = kind;
      pick = $urandom_range(0, 99);
      if (pick < 8)
         e.status = STATUS_OFF;
      else if (pick < 14)
         e.status = STATUS_SPARE;
      else if (pick < 50)
         e.status = STATUS_FILL;
      else
         e.status = STATUS_FLASH;
      if (kind == TYPE_FLIGHT && e.status == STATUS_FLASH) begin
         // noisy climb, so the maxima keep moving for most of the run
         for (int k = 0; k < 3; k++)
            trend[k] += int'($urandom_range(0, 40000)) - 12000;
         e.height       = trend[0];
         e.velocity     = trend[1];
         e.acceleration = trend[2];
      end else begin
         // entries that cannot touch the maxima carry full-range values
         e.height       = $urandom;
         e.velocity     = $urandom;
         e.acceleration = $urandom;
      end
      return e;
   endfunction

   // bursts of one type mimic the repetitions of a sensor task iteration
   task automatic send_random(input int count);
      int                sent;
      int                burst;
      logic [TYPE_W-1:0] kind;
      sent = 0;
      while (sent < count) begin
         kind  = random_type();
         burst = $urandom_range(1, 4);
         repeat (burst) begin
            send_entry(random_entry(kind));
            sent++;
         end
      end
   endtask

   task automatic run_phase(input logic [MASK_W-1:0] mask, input logic [RATE_W-1:0] rate,
                            input int count, input bit hold, input bit quiet);
      settle();
      configure(mask, rate);
      req_gap_pct = quiet ? 0 : 12 * $urandom_range(0, 2);
      rsp_gap_pct = quiet ? 0 : 12 * $urandom_range(0, 2);
      if (hold) begin
         // sender keeps offering while the receiver holds off
         req_gap_pct   = 0;
         stall_request = 1'b1;
      end
      send_random(count);
   endtask

   initial begin : stimulus
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_timestamp       = '0;
      req_entry_type      = '0;
      req_recorder_status = STATUS_OFF;
      req_height          = '0;
      req_velocity        = '0;
      req_acceleration    = '0;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;
      req_gap_pct         = 0;
      rsp_gap_pct         = 0;
      stall_request       = 1'b0;
      now_ms              = 32'd1000;
      for (int k = 0; k < 3; k++)
         trend[k] = -(1 << 18);
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // reset settings: all types enabled, no decimation, every type kept
      for (int t = 0; t < NUM_TYPES; t++)
         send_fields(32'd10 + t, TYPE_W'(t), STATUS_FILL, '0, '0, '0);
      // type codes past the last one have no mask bit
      send_fields(32'd30, TYPE_W'(NUM_TYPES), STATUS_FILL, '0, '0, '0);
      send_fields(32'd31, '1, STATUS_FILL, '0, '0, '0);
      // recorder off rejects, spare status admits
      send_fields(32'd32, TYPE_IMU, STATUS_OFF, '0, '0, '0);
      send_fields(32'd33, TYPE_LAST, STATUS_SPARE, '0, '0, '0);
      // most negative height never replaces the reset value
      send_fields(32'd100, TYPE_FLIGHT, STATUS_FLASH, MOST_NEG, 32'sd5 <<< 16, -32'sd3);
      // equal values keep the earlier timestamps
      send_fields(32'd200, TYPE_FLIGHT, STATUS_FLASH, MOST_NEG, 32'sd5 <<< 16, -32'sd3);
      // large flight values outside write-to-flash leave the maxima alone
      send_fields(32'd300, TYPE_FLIGHT, STATUS_SPARE, MOST_POS, MOST_POS, MOST_POS);
      send_fields(32'd400, TYPE_FLIGHT, STATUS_FILL, MOST_POS, MOST_POS, MOST_POS);
      // everything masked, largest rate index
      settle();
      configure('0, '1);
      send_fields(32'd500, TYPE_FLIGHT, STATUS_FLASH, MOST_POS, MOST_POS, MOST_POS);
      send_fields(32'd501, TYPE_IMU, STATUS_FILL, '0, '0, '0);

      // random phases over a spread of mask and rate settings
      run_phase(TYPE_MASK_RESET, 4'd1, 80, 1'b1, 1'b0);
      run_phase(TYPE_MASK_RESET, 4'd9, 90, 1'b0, 1'b0);
      run_phase(MASK_W'($urandom | $urandom), 4'd3, 80, 1'b0, 1'b0);
      run_phase(TYPE_MASK_RESET, 4'd15, 90, 1'b0, 1'b0);
      run_phase(MASK_W'($urandom | $urandom), RATE_W'($urandom_range(0, 15)), 80,
                1'b0, 1'b0);
      run_phase(TYPE_MASK_RESET, 4'd0, 60, 1'b0, 1'b0);
      run_phase(MASK_W'($urandom | $urandom), 4'd4, 80, 1'b0, 1'b0);
      // last stretch with no idling on either side
      run_phase(TYPE_MASK_RESET, 4'd2, 70, 1'b0, 1'b1);
      // maxima reach the top of the range, then an equal entry must not move them
      send_fields(now_ms + 1, TYPE_FLIGHT, STATUS_FLASH, MOST_POS, MOST_POS, MOST_POS);
      send_fields(now_ms + 2, TYPE_FLIGHT, STATUS_FLASH, MOST_POS, MOST_POS, MOST_POS);
      settle();

      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

### files.f
rtl/core/rdf_pkg.sv
rtl/core/rdf_decim_ctr.sv
rtl/core/record_decimation_filter.sv
tb/rdf_checker.sv
tb/tb_record_decimation_filter.sv
